[hw/rtl/afp_pkg.sv]
// shared types and constants for the ascii pose frame parser
// no dependencies; used by afp_store, afp_field and ascii_pose_frame_parser
`timescale 1ns / 1ps
`default_nettype none

package afp_pkg;

	localparam logic [7:0] CHAR_START = 8'h53;
	localparam logic [7:0] CHAR_END   = 8'h45;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// only the first sixteen bytes of a frame are ever parsed
	localparam int STORE_DEPTH = 16;
	localparam int FIELD_LEN   = 4;
	localparam int Y_AT        = 0;
	localparam int X_AT        = 8;
	localparam int THETA_AT    = 12;

	localparam int POSE_OFFSET = 5000;
	localparam int VALUE_W     = 15;
	localparam int RESULT_W    = 14;

	typedef logic [7:0] char_t;
	typedef logic [STORE_DEPTH-1:0][7:0] store_t;
	typedef logic [FIELD_LEN-1:0][7:0] field_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [RESULT_W-1:0] result_t;

endpackage

`default_nettype wire

[hw/rtl/ascii_pose_frame_parser.sv]
// top level of the ascii pose frame parser: byte store, field parsers, result register
// depends on afp_pkg, afp_store and afp_field
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per beat on rx_byte and accepts a new beat every cycle
// unless a finished result is still held by a stalled result port. 'S' restarts
// the frame at entry 0 without clearing it, later bytes advance the write
// position while it stays within BUFFER_DEPTH, storing only entries 0-15, and 'E'
// parses y from bytes 0-3, x from 8-11 and theta from 12-15, clears the store and
// goes idle. An 'E' beat's result appears in the cycle after its acceptance; the
// parse is a single combinational pass from the byte store into the result register.
// Results are x-5000, y-5000 and 5000-theta as 14-bit two's complement.

module ascii_pose_frame_parser #(
	parameter int BUFFER_DEPTH = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     rx_valid,
	output logic                    rx_stall,
	input  wire  [7:0]              rx_byte,
	output logic                    res_valid,
	input  wire                     res_stall,
	output logic signed [13:0]      x_error,
	output logic signed [13:0]      y_error,
	output logic signed [13:0]      heading_error
);

	logic             beat;
	logic             is_end;
	afp_pkg::store_t  frame;
	afp_pkg::value_t  y_val;
	afp_pkg::value_t  x_val;
	afp_pkg::value_t  t_val;
	logic             res_valid_q;
	afp_pkg::result_t x_error_q;
	afp_pkg::result_t y_error_q;
	afp_pkg::result_t heading_error_q;

	assign rx_stall = res_valid_q && res_stall;
	assign beat     = rx_valid && !rx_stall;
	assign is_end   = (rx_byte == afp_pkg::CHAR_END);

	afp_store #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.rx_byte(rx_byte),
		.frame  (frame)
	);

	afp_field u_y (
		.chars(frame[afp_pkg::Y_AT +: afp_pkg::FIELD_LEN]),
		.value(y_val)
	);

	afp_field u_x (
		.chars(frame[afp_pkg::X_AT +: afp_pkg::FIELD_LEN]),
		.value(x_val)
	);

	afp_field u_t (
		.chars(frame[afp_pkg::THETA_AT +: afp_pkg::FIELD_LEN]),
		.value(t_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (beat && is_end) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat && is_end) begin
			x_error_q       <= afp_pkg::RESULT_W'(16'(x_val) - 16'(afp_pkg::POSE_OFFSET));
			y_error_q       <= afp_pkg::RESULT_W'(16'(y_val) - 16'(afp_pkg::POSE_OFFSET));
			heading_error_q <= afp_pkg::RESULT_W'(16'(afp_pkg::POSE_OFFSET) - 16'(t_val));
		end
	end

	assign res_valid     = res_valid_q;
	assign x_error       = x_error_q;
	assign y_error       = y_error_q;
	assign heading_error = heading_error_q;

endmodule

`default_nettype wire

[hw/rtl/afp_store.sv]
// frame byte store and write position for the ascii pose frame parser
// depends on afp_pkg
`timescale 1ns / 1ps
`default_nettype none

module afp_store #(
	parameter int BUFFER_DEPTH = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              beat,
	input  afp_pkg::char_t   rx_byte,
	output afp_pkg::store_t  frame
);

	localparam int PosW = $clog2(BUFFER_DEPTH + 2);

	afp_pkg::store_t store_q;
	logic [PosW-1:0] pos_q;
	logic            is_start;
	logic            is_end;
	logic            wr_en;
	logic [PosW-1:0] wr_at;

	assign is_start = (rx_byte == afp_pkg::CHAR_START);
	assign is_end   = (rx_byte == afp_pkg::CHAR_END);
	// position p in 1..BUFFER_DEPTH writes entry p-1 if below STORE_DEPTH; zero is idle
	assign wr_en    = beat && !is_start && !is_end && (pos_q != '0)
	                  && (pos_q <= PosW'(BUFFER_DEPTH));
	assign wr_at    = pos_q - PosW'(1);
	assign frame    = store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (beat) begin
			if (is_start) begin
				pos_q <= PosW'(1);
			end else if (is_end) begin
				pos_q <= '0;
			end else if (wr_en) begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	// bytes past the parsed window only advance the position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (beat && is_end) begin
			store_q <= '0;
		end else begin
			for (int e = 0; e < afp_pkg::STORE_DEPTH; e++) begin
				if (wr_en && wr_at == PosW'(e)) begin
					store_q[e] <= rx_byte;
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/afp_field.sv]
// decimal parse of one four-character field: blanks, optional sign, digits
// depends on afp_pkg
`timescale 1ns / 1ps
`default_nettype none

module afp_field (
	input  afp_pkg::field_t  chars,
	output afp_pkg::value_t  value
);

	logic        skipping;
	logic        collecting;
	logic        neg;
	logic        take;
	logic [13:0] mag;
	afp_pkg::char_t c;

	always_comb begin
		skipping   = 1'b1;
		collecting = 1'b1;
		neg        = 1'b0;
		mag        = '0;
		take       = 1'b0;
		c          = '0;
		for (int i = 0; i < afp_pkg::FIELD_LEN; i++) begin
			c    = chars[i];
			take = 1'b0;
			if (skipping) begin
				if (!(c == afp_pkg::CHAR_SPACE ||
				      (c >= afp_pkg::CHAR_TAB && c <= afp_pkg::CHAR_CR))) begin
					skipping = 1'b0;
					if (c == afp_pkg::CHAR_PLUS || c == afp_pkg::CHAR_MINUS) begin
						neg = (c == afp_pkg::CHAR_MINUS);
					end else begin
						take = 1'b1;
					end
				end
			end else begin
				take = 1'b1;
			end
			// first non-digit ends the field, fraction included
			if (take && collecting) begin
				if (c >= afp_pkg::CHAR_ZERO && c <= afp_pkg::CHAR_NINE) begin
					mag = (mag * 14'd10) + {10'd0, c[3:0]};
				end else begin
					collecting = 1'b0;
				end
			end
		end
	end

	assign value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

`default_nettype wire
